// File: rtl/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 32;

   // register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] CSR_RLE_MODE    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_FOUR_BYTE   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PIXEL_COUNT = 2'd2;

   localparam logic [7:0]  ALPHA_OPAQUE   = 8'hff;
   localparam logic [6:0]  HDR_COUNT_MASK = 7'h7f;
   localparam logic [31:0] PIXEL_COUNT_RST = 32'd1;

   // one finished pixel or run, as queued between front and back
   typedef struct packed {
      logic [23:0] color;
      logic [7:0]  alpha;
      logic [7:0]  repeat_count;
      logic        last_pixel;
      logic        run_clipped;
   } pix_type;

endpackage

// File: rtl/tgarle_front.sv
// ----------------------------------------------------------------------------
// tgarle_front
// Byte intake: config registers, packet headers, pixel gathering and counting.
// ----------------------------------------------------------------------------
module tgarle_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tgarle_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [tgarle_pkg::CsrDataWidth-1:0]  csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_frame_start,
   output logic                                 push,
   output tgarle_pkg::pix_type                  push_data,
   input  logic                                 push_ready
);

   logic        rle_mode_ff;
   logic        four_byte_ff;
   logic [31:0] pixel_count_ff;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  left_ff, left_in;
   logic        run_ff, run_in;
   logic [23:0] bytes_ff, bytes_in;
   logic [31:0] done_cnt_ff, done_cnt_in;
   logic        img_ff, img_in;

   logic [1:0]  c_phase;
   logic [7:0]  c_left;
   logic        c_run;
   logic [23:0] c_bytes;
   logic [31:0] c_cnt;
   logic        c_img;
   logic [32:0] diff;
   logic        cnt_reached;
   logic        accept;
   logic [2:0]  bpp;
   logic [7:0]  want;
   logic [7:0]  left_after;
   logic        over;
   logic        last;

   assign req_ready = push_ready;
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_mode_ff    <= 1'b1;
         four_byte_ff   <= 1'b1;
         pixel_count_ff <= tgarle_pkg::PIXEL_COUNT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tgarle_pkg::CSR_RLE_MODE:    rle_mode_ff    <= csr_wdata[0];
            tgarle_pkg::CSR_FOUR_BYTE:   four_byte_ff   <= csr_wdata[0];
            tgarle_pkg::CSR_PIXEL_COUNT: pixel_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         left_ff     <= '0;
         run_ff      <= 1'b0;
         bytes_ff    <= '0;
         done_cnt_ff <= '0;
         img_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         left_ff     <= left_in;
         run_ff      <= run_in;
         bytes_ff    <= bytes_in;
         done_cnt_ff <= done_cnt_in;
         img_ff      <= img_in;
      end
   end

   always_comb begin
      // frame start clears the decoding state before the byte is used
      c_phase = req_frame_start ? 2'd0  : phase_ff;
      c_left  = req_frame_start ? 8'd0  : left_ff;
      c_run   = req_frame_start ? 1'b0  : run_ff;
      c_bytes = req_frame_start ? 24'd0 : bytes_ff;
      c_cnt   = req_frame_start ? 32'd0 : done_cnt_ff;
      c_img   = req_frame_start ? 1'b0  : img_ff;

      diff        = {1'b0, pixel_count_ff} - {1'b0, c_cnt};
      cnt_reached = diff[32] | (diff[31:0] == 32'd0);
      bpp         = four_byte_ff ? 3'd4 : 3'd3;

      want       = rle_mode_ff ? (c_run ? c_left : 8'd1) : 8'd1;
      left_after = rle_mode_ff ? (c_run ? 8'd0 : c_left - 8'd1) : c_left;
      over       = {24'd0, want} > diff[31:0];
      last       = {24'd0, want} >= diff[31:0];

      phase_in    = phase_ff;
      left_in     = left_ff;
      run_in      = run_ff;
      bytes_in    = bytes_ff;
      done_cnt_in = done_cnt_ff;
      img_in      = img_ff;
      push        = 1'b0;
      push_data   = '0;

      if (accept) begin
         phase_in    = c_phase;
         left_in     = c_left;
         run_in      = c_run;
         bytes_in    = c_bytes;
         done_cnt_in = c_cnt;
         img_in      = c_img;
         priority if (c_img || cnt_reached) begin
            img_in = 1'b1;
         end else if (rle_mode_ff && (c_left == 8'd0)) begin
            // packet header
            left_in  = {1'b0, req_data_byte[6:0] & tgarle_pkg::HDR_COUNT_MASK} + 8'd1;
            run_in   = req_data_byte[7];
            phase_in = 2'd0;
         end else begin
            unique case (c_phase)
               2'd0: bytes_in = {16'd0, req_data_byte};
               2'd1: bytes_in[15:8]  = req_data_byte;
               2'd2: bytes_in[23:16] = req_data_byte;
               default: ;  // alpha byte, or dropped when 3-byte pixels
            endcase
            if (({1'b0, c_phase} + 3'd1) < bpp) begin
               phase_in = c_phase + 2'd1;
            end else begin
               phase_in               = 2'd0;
               push                   = 1'b1;
               push_data.color        = bytes_in;
               push_data.alpha        = four_byte_ff ? req_data_byte : tgarle_pkg::ALPHA_OPAQUE;
               push_data.repeat_count = over ? diff[7:0] : want;
               push_data.last_pixel   = last;
               push_data.run_clipped  = over |
                  (last & rle_mode_ff & ~c_run & (left_after != 8'd0));
               // when the image completes the count lands exactly on pixel_count
               done_cnt_in = last ? pixel_count_ff : c_cnt + {24'd0, want};
               left_in     = last ? 8'd0 : left_after;
               if (last) begin
                  img_in = 1'b1;
               end
            end
         end
      end
   end

endmodule

// File: rtl/tgarle_fifo.sv
// ----------------------------------------------------------------------------
// tgarle_fifo
// Two-entry queue of decoded pixels between front and back.
// ----------------------------------------------------------------------------
module tgarle_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  tgarle_pkg::pix_type  wr_data,
   output logic                 rd_valid,
   input  logic                 rd_pop,
   output tgarle_pkg::pix_type  rd_data
);

   tgarle_pkg::pix_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr;
   logic       do_rd;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid & wr_ready;
   assign do_rd    = rd_pop & rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/tgarle_back.sv
// ----------------------------------------------------------------------------
// tgarle_back
// Output stage: assembles the pixel word and holds it for the receiver.
// ----------------------------------------------------------------------------
module tgarle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  tgarle_pkg::pix_type  q_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_pixel_word,
   output logic [7:0]           rsp_repeat_count,
   output logic                 rsp_last_pixel,
   output logic                 rsp_run_clipped
);

   logic        valid_ff, valid_in;
   logic [31:0] word_ff;
   logic [7:0]  rep_ff;
   logic        last_ff;
   logic        clip_ff;

   // load when the output register is empty or being drained
   assign q_pop    = q_valid & (~valid_ff | rsp_ready);
   assign valid_in = q_pop | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         word_ff <= {q_data.alpha, q_data.color};
         rep_ff  <= q_data.repeat_count;
         last_ff <= q_data.last_pixel;
         clip_ff <= q_data.run_clipped;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_word   = word_ff;
   assign rsp_repeat_count = rep_ff;
   assign rsp_last_pixel   = last_ff;
   assign rsp_run_clipped  = clip_ff;

endmodule

// File: rtl/tga_rle_pixel_decoder_top.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Truecolour TGA pixel-data decoder, raw or run-length, 24 or 32 bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel-data byte per request in file order; frame_start
//   on the first byte of an image restarts decoding. rsp_* gives one 32-bit
//   pixel word with its repeat count for each finished pixel or run, with
//   last_pixel on the word that completes pixel_count and run_clipped when a
//   packet was cut at the image end. Header bytes, partial pixel bytes and
//   bytes after the image give no response.
//   The csr_* port sets rle_mode, four_byte_pixels and pixel_count; write it
//   only while the decoder is idle.
//   Throughput: one byte per cycle while the queue has room, set by the
//   combinational byte decode in the front stage. A pixel's response passes
//   through the queue, written on the edge that accepts the request holding
//   its final byte, and then through the output register.
//   Reset: registers return to rle mode, 32-bit pixels, pixel_count 1, and
//   the decoder waits for a header byte. When the receiver stalls, the output
//   register and two-entry queue absorb results; req_ready drops once the
//   queue is full.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tgarle_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [tgarle_pkg::CsrDataWidth-1:0]  csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_frame_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [31:0]                          rsp_pixel_word,
   output logic [7:0]                           rsp_repeat_count,
   output logic                                 rsp_last_pixel,
   output logic                                 rsp_run_clipped
);

   logic                push;
   logic                push_ready;
   tgarle_pkg::pix_type push_data;
   logic                q_valid;
   logic                q_pop;
   tgarle_pkg::pix_type q_data;

   tgarle_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .push            (push),
      .push_data       (push_data),
      .push_ready      (push_ready)
   );

   tgarle_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push),
      .wr_ready (push_ready),
      .wr_data  (push_data),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_data  (q_data)
   );

   tgarle_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_data           (q_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_word   (rsp_pixel_word),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_last_pixel   (rsp_last_pixel),
      .rsp_run_clipped  (rsp_run_clipped)
   );

endmodule

// File: rtl/tgarle_checker.sv
// ----------------------------------------------------------------------------
// tgarle_checker
// Port-level checks of the decoder's response channel, bound to the top.
// ----------------------------------------------------------------------------
module tgarle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pixel_word,
   input logic [7:0]  rsp_repeat_count,
   input logic        rsp_last_pixel,
   input logic        rsp_run_clipped
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_word)
         && $stable(rsp_repeat_count) && $stable(rsp_last_pixel)
         && $stable(rsp_run_clipped))
      else $error("response changed while stalled");

   a_rep_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count != 8'd0)
      else $error("zero repeat count");

   // clipping only happens on the word that ends the image
   a_clip_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_clipped |-> rsp_last_pixel)
      else $error("clipped response not marked last");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind tga_rle_pixel_decoder_top tgarle_checker u_tgarle_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pixel_word   (rsp_pixel_word),
   .rsp_repeat_count (rsp_repeat_count),
   .rsp_last_pixel   (rsp_last_pixel),
   .rsp_run_clipped  (rsp_run_clipped)
);

// File: dv/tga_rle_pixel_decoder_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top_test
// Streams TGA pixel-data bytes, raw and run-length, 24 and 32 bit, into the
// decoder with random gaps and receiver stalls. Every accepted byte runs
// through a local decoder model whose pixel runs are checked field by field
// against the response stream in order.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top_test;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned LONG_STALL = 80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } byte_req_type;

   typedef struct packed {
      logic [31:0] pixel_word;
      logic [7:0]  repeat_count;
      logic        last_pixel;
      logic        run_clipped;
   } pixel_run_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [tgarle_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [tgarle_pkg::CsrDataWidth-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = '0;
   logic req_frame_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_pixel_word;
   logic [7:0] rsp_repeat_count;
   logic rsp_last_pixel;
   logic rsp_run_clipped;

   tga_rle_pixel_decoder_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_word   (rsp_pixel_word),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_last_pixel   (rsp_last_pixel),
      .rsp_run_clipped  (rsp_run_clipped)
   );

   always #6 clock = ~clock;

   byte_req_type  pending_bytes[$];
   pixel_run_type expected_runs[$];
   int unsigned items_sent = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   logic no_idle = 1'b0;
   int unsigned hold_req = 0;
   int unsigned holds_taken = 0;
   int unsigned send_gap = 0;
   int unsigned stall_cycles = 0;
   byte_req_type next_req;
   pixel_run_type got_run;

   // decoder model: configuration copy and decoding state
   logic        rle_on;
   logic        quad_px;
   logic [31:0] image_pixels;
   logic [2:0]  byte_pos;
   logic [7:0]  pkt_remaining;
   logic        pkt_repeat;
   logic [23:0] color_acc;
   logic [31:0] px_emitted;
   logic        frame_full;

   task automatic clear_decode_state();
      byte_pos = '0;
      pkt_remaining = '0;
      pkt_repeat = 1'b0;
      color_acc = '0;
      px_emitted = '0;
      frame_full = 1'b0;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic fs);
      int unsigned   bpp;
      int unsigned   want;
      int unsigned   rep;
      int unsigned   left;
      logic          clipped;
      pixel_run_type run;
      if (fs)
         clear_decode_state();
      if (!frame_full && px_emitted >= image_pixels)
         frame_full = 1'b1;
      if (frame_full)
         return;
      if (rle_on && pkt_remaining == 0) begin
         pkt_remaining = {1'b0, b[6:0]} + 8'd1;
         pkt_repeat = b[7];
         byte_pos = '0;
         return;
      end
      bpp = quad_px ? 4 : 3;
      if (byte_pos == 0)
         color_acc = {16'h0, b};
      else if (byte_pos < 3)
         color_acc = color_acc | (24'(b) << (8 * byte_pos));
      if (int'(byte_pos) + 1 < int'(bpp)) begin
         byte_pos = byte_pos + 3'd1;
         return;
      end
      byte_pos = '0;
      left = image_pixels - px_emitted;
      if (rle_on && pkt_repeat) begin
         want = pkt_remaining;
         pkt_remaining = '0;
      end else begin
         want = 1;
         if (rle_on)
            pkt_remaining = pkt_remaining - 8'd1;
      end
      if (want > left) begin
         rep = left;
         clipped = 1'b1;
      end else begin
         rep = want;
         clipped = 1'b0;
      end
      px_emitted = px_emitted + rep;
      run.last_pixel = (px_emitted == image_pixels);
      if (run.last_pixel) begin
         // literal packet cut short by the image end
         if (rle_on && !pkt_repeat && pkt_remaining != 0)
            clipped = 1'b1;
         frame_full = 1'b1;
         pkt_remaining = '0;
      end
      run.pixel_word = {(quad_px ? b : tgarle_pkg::ALPHA_OPAQUE), color_acc};
      run.repeat_count = rep[7:0];
      run.run_clipped = clipped;
      expected_runs.push_back(run);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rle_on = 1'b1;
         quad_px = 1'b1;
         image_pixels = tgarle_pkg::PIXEL_COUNT_RST;
         clear_decode_state();
      end else begin
         if (req_valid && req_ready)
            decode_byte(req_data_byte, req_frame_start);
         if (req_valid && !req_ready) begin
            // hold the offered request
         end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0 && !no_idle && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 4);
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            next_req = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_req.data_byte;
            req_frame_start <= next_req.frame_start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_runs.size() == 0) begin
               $error("unexpected pixel word %h", rsp_pixel_word);
               mismatch_count++;
            end else begin
               got_run = expected_runs.pop_front();
               if (rsp_pixel_word !== got_run.pixel_word) begin
                  $error("pixel_word: expected %h, got %h",
                         got_run.pixel_word, rsp_pixel_word);
                  mismatch_count++;
               end
               if (rsp_repeat_count !== got_run.repeat_count) begin
                  $error("repeat_count: expected %0d, got %0d",
                         got_run.repeat_count, rsp_repeat_count);
                  mismatch_count++;
               end
               if (rsp_last_pixel !== got_run.last_pixel) begin
                  $error("last_pixel: expected %b, got %b",
                         got_run.last_pixel, rsp_last_pixel);
                  mismatch_count++;
               end
               if (rsp_run_clipped !== got_run.run_clipped) begin
                  $error("run_clipped: expected %b, got %b",
                         got_run.run_clipped, rsp_run_clipped);
                  mismatch_count++;
               end
            end
         end
         if (stall_cycles > 0) begin
            stall_cycles = stall_cycles - 1;
            rsp_ready <= 1'b0;
         end else if (hold_req != holds_taken) begin
            holds_taken = holds_taken + 1;
            stall_cycles = LONG_STALL - 1;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall_cycles = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic fs);
      pending_bytes.push_back('{data_byte: b, frame_start: fs});
      items_sent++;
   endtask

   task automatic push_pixel(input int unsigned bpp, inout logic lead);
      for (int k = 0; k < bpp; k++) begin
         push_byte(8'($urandom), lead);
         lead = 1'b0;
      end
   endtask

   // all requests taken, all responses seen, decoder settled
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_runs.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [tgarle_pkg::CsrIdxWidth-1:0] idx,
                            input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         tgarle_pkg::CSR_RLE_MODE:    rle_on = val[0];
         tgarle_pkg::CSR_FOUR_BYTE:   quad_px = val[0];
         tgarle_pkg::CSR_PIXEL_COUNT: image_pixels = val;
         default: ;
      endcase
   endtask

   task automatic close_csr();
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_config(input logic rle, input logic quad, input logic [31:0] count);
      wait_idle();
      write_csr(tgarle_pkg::CSR_RLE_MODE, {31'b0, rle});
      write_csr(tgarle_pkg::CSR_FOUR_BYTE, {31'b0, quad});
      write_csr(tgarle_pkg::CSR_PIXEL_COUNT, count);
      close_csr();
   endtask

   // one image under the current setting, sometimes broken off early
   task automatic send_image();
      int unsigned bpp;
      int unsigned made;
      int unsigned len;
      int unsigned cut;
      int unsigned start;
      int unsigned extra;
      logic        lead;
      logic        is_run;
      bpp = quad_px ? 4 : 3;
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : 0;
      made = 0;
      start = items_sent;
      lead = 1'b1;
      while (made < image_pixels && items_sent - start < 90
             && !(cut != 0 && items_sent - start >= cut)) begin
         if (rle_on) begin
            is_run = 1'($urandom_range(0, 1));
            if (is_run)
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
            else
               len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
            push_byte({is_run, 7'(len - 1)}, lead);
            lead = 1'b0;
            if (is_run) begin
               push_pixel(bpp, lead);
            end else begin
               for (int p = 0; p < len; p++)
                  push_pixel(bpp, lead);
            end
            made = made + len;
         end else begin
            push_pixel(bpp, lead);
            made = made + 1;
         end
      end
      // trailing bytes: partial pixel when broken off, else ignored
      extra = (cut != 0) ? $urandom_range(0, bpp - 1) : $urandom_range(0, 3);
      for (int k = 0; k < extra; k++)
         push_byte(8'($urandom), 1'b0);
   endtask

   initial begin
      logic [31:0] count;
      int unsigned pick;
      int unsigned n;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset setting: single-pixel run of a 32-bit image, then a byte past the end
      push_byte(8'h80, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'haa, 1'b0);

      // longest run, then a run clipped at the image end
      apply_config(1'b1, 1'b1, 32'd130);
      push_byte(8'hff, 1'b1);
      repeat (4) push_byte(8'hff, 1'b0);
      push_byte(8'h82, 1'b0);
      repeat (4) push_byte(8'h00, 1'b0);
      push_byte(8'h55, 1'b0);

      // literal packet cut by the image end, 24-bit pixels
      apply_config(1'b1, 1'b0, 32'd2);
      push_byte(8'h05, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(8'h02, 1'b0);
      push_byte(8'h03, 1'b0);
      push_byte(8'hfe, 1'b0);
      push_byte(8'hfd, 1'b0);
      push_byte(8'hfc, 1'b0);
      push_byte(8'h10, 1'b0);

      // raw, count 4294836225; switch to 3-byte pixels with the alpha byte pending
      apply_config(1'b0, 1'b1, 32'd4294836225);
      push_byte(8'h11, 1'b1);
      push_byte(8'h22, 1'b0);
      push_byte(8'h33, 1'b0);
      wait_idle();
      write_csr(tgarle_pkg::CSR_FOUR_BYTE, 32'd0);
      close_csr();
      push_byte(8'h44, 1'b0);
      // lower the count to the pixels already given out
      wait_idle();
      write_csr(tgarle_pkg::CSR_PIXEL_COUNT, 32'd1);
      close_csr();
      push_byte(8'h99, 1'b0);
      push_byte(8'h77, 1'b0);

      // mode changes inside one image, state carries across
      apply_config(1'b1, 1'b1, 32'd10);
      push_byte(8'h83, 1'b1);
      repeat (4) push_byte(8'($urandom), 1'b0);
      push_byte(8'h02, 1'b0);
      repeat (4) push_byte(8'($urandom), 1'b0);
      wait_idle();
      write_csr(tgarle_pkg::CSR_RLE_MODE, 32'd0);
      close_csr();
      repeat (4) push_byte(8'($urandom), 1'b0);
      wait_idle();
      write_csr(tgarle_pkg::CSR_RLE_MODE, 32'd1);
      close_csr();
      repeat (8) push_byte(8'($urandom), 1'b0);
      push_byte(8'h81, 1'b0);
      repeat (4) push_byte(8'($urandom), 1'b0);

      // long receiver hold-off while raw pixels keep coming
      apply_config(1'b0, 1'b0, 32'd40);
      hold_req <= hold_req + 1;
      n = 1;
      repeat (120) begin
         push_byte(8'($urandom), n[0]);
         n = 0;
      end

      while (items_sent < 430) begin
         if (items_sent > 360)
            no_idle <= 1'b1;
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
         end else begin
            if (pick < 6) begin
               n = $urandom_range(0, 19);
               if (n == 0)
                  count = 32'd4294836225;
               else if (n < 3)
                  count = $urandom_range(100, 300);
               else
                  count = $urandom_range(1, 16);
               apply_config($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), count);
            end
            send_image();
         end
      end

      while (pending_bytes.size() != 0 || req_valid || expected_runs.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_runs.size() != 0) begin
         $error("%0d pixel runs never arrived", expected_runs.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
